FILE: rtl/csc_pkg.sv
// ----------------------------------------------------------------------------
// csc_pkg: shared types and constants of the spline transfer curve
// Table geometry, field widths, register indexes and sequencer codes.
// ----------------------------------------------------------------------------
package csc_pkg;

  localparam int MAX_POINTS = 16;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = 5;
  localparam int DATA_W     = 16;
  localparam int ENTRY_W    = 2 * DATA_W;

  // datapath widths
  localparam int T_W    = 17;  // t in [0, 65536]
  localparam int MA_W   = 35;  // multiplier operand A
  localparam int MB_W   = 18;  // multiplier operand B
  localparam int PROD_W = MA_W + MB_W;
  localparam int ACC_W  = 66;

  // configuration register indexes
  localparam logic CFG_TENSION = 1'b0;
  localparam logic CFG_COUNT   = 1'b1;

  localparam logic [DATA_W-1:0] TENSION_RST = 16'h2000;

  // item kinds
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_EVAL = 1'b1;

  // arithmetic sequencer steps
  localparam logic [3:0] MS_T2     = 4'd0;
  localparam logic [3:0] MS_T2_CAP = 4'd1;
  localparam logic [3:0] MS_T3     = 4'd2;
  localparam logic [3:0] MS_T3_CAP = 4'd3;
  localparam logic [3:0] MS_BASIS  = 4'd4;
  localparam logic [3:0] MS_TAN_A  = 4'd5;
  localparam logic [3:0] MS_TAN_B  = 4'd6;
  localparam logic [3:0] MS_TAN_S  = 4'd7;
  localparam logic [3:0] MS_SC_LO  = 4'd8;
  localparam logic [3:0] MS_SC_HI  = 4'd9;
  localparam logic [3:0] MS_SC_SUM = 4'd10;
  localparam logic [3:0] MS_P1     = 4'd11;
  localparam logic [3:0] MS_P2     = 4'd12;
  localparam logic [3:0] MS_SUM    = 4'd13;
  localparam logic [3:0] MS_FINAL  = 4'd14;

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_FIRST = 8'b0000_0010,
    ST_LAST  = 8'b0000_0100,
    ST_SCAN  = 8'b0000_1000,
    ST_P3    = 8'b0001_0000,
    ST_DIV   = 8'b0010_0000,
    ST_MATH  = 8'b0100_0000,
    ST_OUT   = 8'b1000_0000
  } csc_state_t;

endpackage

FILE: rtl/csc_ram.sv
// ----------------------------------------------------------------------------
// csc_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module csc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/cardinal_spline_transfer_curve.sv
// ----------------------------------------------------------------------------
// cardinal_spline_transfer_curve: control-point transfer curve evaluator
// Maps Q4.12 queries through a linear or cardinal Hermite spline curve.
// ----------------------------------------------------------------------------
// A load beat writes one control point and leaves the block idle. An evaluate
// beat keeps the input stalled until its result beat is taken. With fewer
// than two points the query passes through and out_valid rises in the cycle
// after acceptance; a low clamp ends in ST_FIRST and a high clamp in ST_LAST.
// Otherwise the block reads the first and last points, walks the point table
// one entry per cycle to find the segment (plus a fetch of the far neighbour
// in ST_P3 when there is one), runs a restoring divider one quotient bit per
// cycle and then steps one shared 35x18 multiplier through the Hermite basis
// and weighted sum, or through one linear product for two points.
module cardinal_spline_transfer_curve
  import csc_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic                     cfg_index,
  input  logic [DATA_W-1:0]        cfg_wdata,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     in_kind,
  input  logic [3:0]               in_point_index,
  input  logic signed [DATA_W-1:0] in_point_in,
  input  logic signed [DATA_W-1:0] in_point_out,
  input  logic signed [DATA_W-1:0] in_query_value,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [DATA_W-1:0] out_curve_value,
  output logic                     out_saturated
);

  csc_state_t state_r, state_nxt;

  logic signed [DATA_W-1:0] tension_r;
  logic [CNT_W-1:0]         count_r;

  logic signed [DATA_W-1:0] query_r, query_nxt;
  logic [CNT_W-1:0]         n_r, n_nxt;
  logic [IDX_W-1:0]         idx_r, idx_nxt;
  logic signed [DATA_W-1:0] prev_x_r, prev_x_nxt;
  logic signed [DATA_W-1:0] prev_y_r, prev_y_nxt;
  logic signed [DATA_W-1:0] pp_y_r, pp_y_nxt;
  logic signed [DATA_W-1:0] p0_r, p0_nxt, p1_r, p1_nxt, p2_r, p2_nxt, p3_r, p3_nxt;
  logic [T_W-1:0]           den_r, den_nxt;
  logic [T_W:0]             rem_r, rem_nxt;
  logic [T_W-2:0]           quo_r, quo_nxt;
  logic [4:0]               dcnt_r, dcnt_nxt;
  logic [T_W-1:0]           t_r, t_nxt;
  logic [3:0]               step_r, step_nxt;
  logic signed [MA_W-1:0]   t2_r, t2_nxt, t3_r, t3_nxt;
  logic signed [MA_W-1:0]   h1_r, h1_nxt, h2_r, h2_nxt, h3_r, h3_nxt, h4_r, h4_nxt;
  logic signed [ACC_W-1:0]  acc_r, acc_nxt, tmp_r, tmp_nxt;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [DATA_W-1:0] out_val_r, out_val_nxt;
  logic                     out_sat_r, out_sat_nxt;

  logic signed [MA_W-1:0]   mul_a;
  logic signed [MB_W-1:0]   mul_b;
  logic [IDX_W-1:0]         ram_raddr;
  logic [ENTRY_W-1:0]       ram_rdata;
  logic signed [DATA_W-1:0] rd_x, rd_y;
  logic                     in_acc, load_we;
  logic [CNT_W-1:0]         n_eff;

  // combinational helpers
  logic signed [T_W-1:0]    num_w, den_w, dp20, dp31, dlin;
  logic                     div_ge;
  logic [T_W:0]             rem_sub;
  logic signed [MB_W-1:0]   s_w;
  logic signed [MA_W-1:0]   t_ext, t2_x2, t2_x3, t3_x2, t_sh16;
  logic signed [ACC_W-1:0   ] prod_ext, acc_rnd;
  logic signed [33:0]       y_w;
  logic signed [ACC_W-1:0]  lin_rnd;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign load_we   = in_acc && (in_kind == KIND_LOAD);
  assign n_eff     = (count_r > CNT_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS) : count_r;
  assign rd_x      = ram_rdata[ENTRY_W-1:DATA_W];
  assign rd_y      = ram_rdata[DATA_W-1:0];
  assign out_valid = (state_r == ST_OUT);
  assign out_curve_value = out_val_r;
  assign out_saturated   = out_sat_r;

  // point table: x in the upper half, y in the lower half
  csc_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_POINTS)) u_table (
    .clk   (clk),
    .we    (load_we),
    .waddr (in_point_index[IDX_W-1:0]),
    .wdata ({in_point_in, in_point_out}),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tension_r <= TENSION_RST;
      count_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TENSION: tension_r <= cfg_wdata;
        CFG_COUNT:   count_r   <= cfg_wdata[CNT_W-1:0];
        default:     ;
      endcase
    end
  end

  // segment span, divider step and basis terms
  assign num_w   = T_W'(query_r) - T_W'(prev_x_r);
  assign den_w   = T_W'(rd_x) - T_W'(prev_x_r);
  assign dp20    = T_W'(p2_r) - T_W'(p0_r);
  assign dp31    = T_W'(p3_r) - T_W'(p1_r);
  assign dlin    = T_W'(p2_r) - T_W'(p1_r);
  assign div_ge  = (rem_r >= {1'b0, den_r});
  assign rem_sub = div_ge ? (rem_r - {1'b0, den_r}) : rem_r;
  assign s_w     = 18'sd16384 - MB_W'(tension_r);
  assign t_ext   = MA_W'(t_r);
  assign t2_x2   = t2_r <<< 1;
  assign t2_x3   = t2_x2 + t2_r;
  assign t3_x2   = t3_r <<< 1;
  assign t_sh16  = t_ext <<< 16;
  assign prod_ext = ACC_W'(prod_r);
  assign acc_rnd  = acc_r + (ACC_W'(1) <<< 31);
  assign y_w      = acc_rnd[ACC_W-1:32];
  assign lin_rnd  = prod_ext + (ACC_W'(1) <<< 15);

  // shared multiplier operand selection
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_r == ST_MATH) begin
      if (n_r == CNT_W'(2)) begin
        mul_a = MA_W'(dlin);
        mul_b = MB_W'(t_r);
      end else begin
        case (step_r)
          MS_T2:     begin mul_a = t_ext; mul_b = MB_W'(t_r); end
          MS_T3:     begin mul_a = t2_r;  mul_b = MB_W'(t_r); end
          MS_TAN_A:  begin mul_a = h3_r;  mul_b = MB_W'(dp20); end
          MS_TAN_B:  begin mul_a = h4_r;  mul_b = MB_W'(dp31); end
          MS_SC_LO:  begin mul_a = MA_W'(acc_r[16:0]); mul_b = s_w; end
          MS_SC_HI:  begin mul_a = acc_r[51:17]; mul_b = s_w; end
          MS_P1:     begin mul_a = h1_r;  mul_b = MB_W'(p1_r); end
          MS_P2:     begin mul_a = h2_r;  mul_b = MB_W'(p2_r); end
          default:   ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  // sequencer
  always_comb begin
    state_nxt   = state_r;
    query_nxt   = query_r;
    n_nxt       = n_r;
    idx_nxt     = idx_r;
    prev_x_nxt  = prev_x_r;
    prev_y_nxt  = prev_y_r;
    pp_y_nxt    = pp_y_r;
    p0_nxt      = p0_r;
    p1_nxt      = p1_r;
    p2_nxt      = p2_r;
    p3_nxt      = p3_r;
    den_nxt     = den_r;
    rem_nxt     = rem_r;
    quo_nxt     = quo_r;
    dcnt_nxt    = dcnt_r;
    t_nxt       = t_r;
    step_nxt    = step_r;
    t2_nxt      = t2_r;
    t3_nxt      = t3_r;
    h1_nxt      = h1_r;
    h2_nxt      = h2_r;
    h3_nxt      = h3_r;
    h4_nxt      = h4_r;
    acc_nxt     = acc_r;
    tmp_nxt     = tmp_r;
    out_val_nxt = out_val_r;
    out_sat_nxt = out_sat_r;
    ram_raddr   = '0;

    case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_kind == KIND_EVAL)) begin
          query_nxt   = in_query_value;
          n_nxt       = n_eff;
          out_sat_nxt = 1'b0;
          if (n_eff < CNT_W'(2)) begin
            out_val_nxt = in_query_value;
            state_nxt   = ST_OUT;
          end else begin
            state_nxt = ST_FIRST;
          end
        end
      end
      // first point: low clamp
      ST_FIRST: begin
        if (query_r < rd_x) begin
          out_val_nxt = rd_y;
          state_nxt   = ST_OUT;
        end else begin
          prev_x_nxt = rd_x;
          prev_y_nxt = rd_y;
          pp_y_nxt   = rd_y;
          ram_raddr  = IDX_W'(n_r - CNT_W'(1));
          state_nxt  = ST_LAST;
        end
      end
      // last point: high clamp
      ST_LAST: begin
        if (query_r > rd_x) begin
          out_val_nxt = rd_y;
          state_nxt   = ST_OUT;
        end else begin
          idx_nxt   = IDX_W'(1);
          ram_raddr = IDX_W'(1);
          state_nxt = ST_SCAN;
        end
      end
      // walk segments until one brackets the query
      ST_SCAN: begin
        if ((query_r >= prev_x_r) && (query_r <= rd_x)) begin
          p0_nxt   = pp_y_r;
          p1_nxt   = prev_y_r;
          p2_nxt   = rd_y;
          p3_nxt   = rd_y;
          den_nxt  = den_w;
          rem_nxt  = {1'b0, num_w};
          quo_nxt  = '0;
          dcnt_nxt = 5'd16;
          if (CNT_W'(idx_r) < (n_r - CNT_W'(1))) begin
            ram_raddr = idx_r + IDX_W'(1);
            state_nxt = ST_P3;
          end else begin
            state_nxt = ST_DIV;
          end
        end else begin
          pp_y_nxt   = prev_y_r;
          prev_x_nxt = rd_x;
          prev_y_nxt = rd_y;
          idx_nxt    = idx_r + IDX_W'(1);
          ram_raddr  = idx_r + IDX_W'(1);
        end
      end
      ST_P3: begin
        p3_nxt    = rd_y;
        state_nxt = ST_DIV;
      end
      // restoring divide, one quotient bit per cycle
      ST_DIV: begin
        if (den_r == '0) begin
          t_nxt     = '0;
          step_nxt  = MS_T2;
          state_nxt = ST_MATH;
        end else if (dcnt_r == '0) begin
          t_nxt     = {quo_r, div_ge};
          step_nxt  = MS_T2;
          state_nxt = ST_MATH;
        end else begin
          rem_nxt  = {rem_sub[T_W-1:0], 1'b0};
          quo_nxt  = {quo_r[T_W-3:0], div_ge};
          dcnt_nxt = dcnt_r - 5'd1;
        end
      end
      ST_MATH: begin
        step_nxt = step_r + 4'd1;
        if (n_r == CNT_W'(2)) begin
          // linear: the registered product is used in the step after the multiply
          if (step_r != MS_T2) begin
            out_val_nxt = p1_r + DATA_W'(lin_rnd >>> 16);
            state_nxt   = ST_OUT;
          end
        end else begin
          case (step_r)
            MS_T2_CAP: t2_nxt = prod_r[MA_W-1:0];
            MS_T3_CAP: t3_nxt = prod_r[MA_W+15:16];
            MS_BASIS: begin
              h1_nxt = t3_x2 - t2_x3 + (MA_W'(1) <<< 32);
              h2_nxt = t2_x3 - t3_x2;
              h3_nxt = t3_r - t2_x2 + t_sh16;
              h4_nxt = t3_r - t2_r;
            end
            MS_TAN_B:  acc_nxt = prod_ext;
            MS_TAN_S:  acc_nxt = acc_r + prod_ext;
            MS_SC_HI:  tmp_nxt = prod_ext;
            MS_SC_SUM: tmp_nxt = tmp_r + (prod_ext <<< 17);
            MS_P1:     acc_nxt = (tmp_r + (ACC_W'(1) <<< 14)) >>> 15;
            MS_P2:     acc_nxt = acc_r + prod_ext;
            MS_SUM:    acc_nxt = acc_r + prod_ext;
            MS_FINAL: begin
              // saturate to Q4.12
              if (y_w > 34'sd32767) begin
                out_val_nxt = 16'sh7FFF;
                out_sat_nxt = 1'b1;
              end else if (y_w < -34'sd32768) begin
                out_val_nxt = 16'sh8000;
                out_sat_nxt = 1'b1;
              end else begin
                out_val_nxt = y_w[DATA_W-1:0];
              end
              state_nxt = ST_OUT;
            end
            default: ;
          endcase
        end
      end
      // hold the result beat until taken
      ST_OUT: begin
        if (!out_stall) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
      dcnt_r  <= '0;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      dcnt_r  <= dcnt_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    query_r   <= query_nxt;
    n_r       <= n_nxt;
    prev_x_r  <= prev_x_nxt;
    prev_y_r  <= prev_y_nxt;
    pp_y_r    <= pp_y_nxt;
    p0_r      <= p0_nxt;
    p1_r      <= p1_nxt;
    p2_r      <= p2_nxt;
    p3_r      <= p3_nxt;
    den_r     <= den_nxt;
    rem_r     <= rem_nxt;
    quo_r     <= quo_nxt;
    t_r       <= t_nxt;
    t2_r      <= t2_nxt;
    t3_r      <= t3_nxt;
    h1_r      <= h1_nxt;
    h2_r      <= h2_nxt;
    h3_r      <= h3_nxt;
    h4_r      <= h4_nxt;
    acc_r     <= acc_nxt;
    tmp_r     <= tmp_nxt;
    out_val_r <= out_val_nxt;
    out_sat_r <= out_sat_nxt;
  end

`ifndef NO_ASSERTIONS
  // a pass-through evaluate shows its result in the next cycle
  a_pass_through: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_kind == KIND_EVAL) && (n_eff < CNT_W'(2))) |=> out_valid)
    else $error("pass-through result not shown");

  // a load beat never produces a result
  a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
    load_we |=> !out_valid)
    else $error("load beat produced a result");

  // divider remainder stays below twice the span
  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_DIV) && (den_r != '0)) |-> (rem_r < ({1'b0, den_r} <<< 1)))
    else $error("divider remainder out of range");

  // the arithmetic sequencer never runs past its last step
  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MATH) |-> (step_r <= MS_FINAL))
    else $error("sequencer step out of range");
`endif

endmodule

FILE: verif/cardinal_spline_transfer_curve_test.sv
// ----------------------------------------------------------------------------
// cardinal_spline_transfer_curve_test: self-checking bench of the curve block
// Loads control points, sweeps tension and point count, and maps queries
// through pass-through, clamp, linear and spline paths. A built-in predictor
// computes every expected beat, and a monitor compares results in order.
// ----------------------------------------------------------------------------
module cardinal_spline_transfer_curve_test
  import csc_pkg::*;
();

  localparam int IDLE_LIMIT = 20000;

  typedef struct {
    logic signed [DATA_W-1:0] value;
    logic                     sat;
  } curve_beat_t;

  logic                     clk;
  logic                     rst_n;
  logic                     cfg_we;
  logic                     cfg_index;
  logic [DATA_W-1:0]        cfg_wdata;
  logic                     in_valid;
  logic                     in_stall;
  logic                     in_kind;
  logic [3:0]               in_point_index;
  logic signed [DATA_W-1:0] in_point_in;
  logic signed [DATA_W-1:0] in_point_out;
  logic signed [DATA_W-1:0] in_query_value;
  logic                     out_valid;
  logic                     out_stall;
  logic signed [DATA_W-1:0] out_curve_value;
  logic                     out_saturated;

  // predictor state
  logic signed [DATA_W-1:0] knot_x[MAX_POINTS];
  logic signed [DATA_W-1:0] knot_y[MAX_POINTS];
  logic signed [DATA_W-1:0] cur_tension;
  logic [4:0]               cur_count;

  curve_beat_t curve_expect[$];
  int  fail_count;
  int  beats_sent;
  int  send_idle_pct;
  int  recv_stall_pct;
  int  hold_off_req;
  int  hold_left;
  int  quiet_cycles;

  cardinal_spline_transfer_curve dut (.*);

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // floor((v + 2^(sh-1)) / 2^sh)
  function automatic longint rnd_shift(input longint v, input int sh);
    return (v + (longint'(1) << (sh - 1))) >>> sh;
  endfunction

  // map one query through the current curve
  function automatic curve_beat_t map_query(input logic signed [DATA_W-1:0] q);
    curve_beat_t r;
    int     n;
    int     lo;
    int     i0;
    int     i3;
    longint num, den, t, y;
    longint p0, p1, p2, p3;
    longint t2, t3, h1, h2, h3, h4, s, tn, acc;
    n = (cur_count > MAX_POINTS) ? MAX_POINTS : int'(cur_count);
    r.sat = 1'b0;
    lo = 0;
    if (n < 2) begin
      y = q;
    end else if (q < knot_x[0]) begin
      y = knot_y[0];
    end else if (q > knot_x[n-1]) begin
      y = knot_y[n-1];
    end else begin
      for (int i = 0; i + 1 < n; i++) begin
        if (q >= knot_x[i] && q <= knot_x[i+1]) begin
          lo = i;
          break;
        end
      end
      num = longint'(q) - longint'(knot_x[lo]);
      den = longint'(knot_x[lo+1]) - longint'(knot_x[lo]);
      t = 0;
      if (den > 0 && num >= 0) t = (num * 65536) / den;
      if (t > 65536) t = 65536;
      p1 = knot_y[lo];
      p2 = knot_y[lo+1];
      if (n == 2) begin
        y = p1 + rnd_shift((p2 - p1) * t, 16);
      end else begin
        i0 = (lo > 0) ? lo - 1 : lo;
        i3 = (lo + 1 < n - 1) ? lo + 2 : lo + 1;
        p0 = knot_y[i0];
        p3 = knot_y[i3];
        t2 = t * t;
        t3 = (t2 * t) >> 16;
        h1 = 2 * t3 - 3 * t2 + (longint'(1) << 32);
        h2 = (longint'(1) << 32) - h1;
        h3 = t3 - 2 * t2 + t * 65536;
        h4 = t3 - t2;
        s  = 16384 - longint'(cur_tension);
        tn = rnd_shift((h3 * (p2 - p0) + h4 * (p3 - p1)) * s, 15);
        acc = h1 * p1 + h2 * p2 + tn;
        y = rnd_shift(acc, 32);
        if (y > 32767) begin
          y = 32767;
          r.sat = 1'b1;
        end
        if (y < -32768) begin
          y = -32768;
          r.sat = 1'b1;
        end
      end
    end
    r.value = y[DATA_W-1:0];
    return r;
  endfunction

  // send one beat and update the predictor when it is taken
  task automatic send_beat(input logic kind, input logic [3:0] idx,
                           input int px, input int py, input int q);
    in_valid       <= 1'b1;
    in_kind        <= kind;
    in_point_index <= idx;
    in_point_in    <= px[DATA_W-1:0];
    in_point_out   <= py[DATA_W-1:0];
    in_query_value <= q[DATA_W-1:0];
    do @(posedge clk); while (in_stall);
    beats_sent++;
    if (kind == KIND_LOAD) begin
      knot_x[idx] = px[DATA_W-1:0];
      knot_y[idx] = py[DATA_W-1:0];
    end else begin
      curve_expect.insert(curve_expect.size(), map_query(q[DATA_W-1:0]));
    end
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic load_point(input int idx, input int px, input int py);
    send_beat(KIND_LOAD, idx[3:0], px, py, int'($urandom));
  endtask

  task automatic eval_query(input int q);
    send_beat(KIND_EVAL, 4'($urandom), int'($urandom), int'($urandom), q);
  endtask

  // pause until every result is back and the block has settled
  task automatic drain;
    in_valid <= 1'b0;
    while (curve_expect.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input int value);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value[DATA_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_TENSION) cur_tension = value[DATA_W-1:0];
    else cur_count = value[4:0];
  endtask

  // count zero and one: query passes through
  task automatic test_pass_through;
    eval_query(-32768);
    eval_query(32767);
    write_reg(CFG_COUNT, 1);
    eval_query(0);
    eval_query(-1);
  endtask

  // fill every slot, then hit knots, linear and spline paths
  task automatic test_directed_curve;
    for (int i = 0; i < MAX_POINTS; i++)
      load_point(i, -32768 + i * 4369, (i % 2) ? 32767 : -32768);
    write_reg(CFG_COUNT, 2);
    eval_query(-32768);
    eval_query(-30000);
    write_reg(CFG_COUNT, 16);
    eval_query(32767);
    eval_query(100);
    write_reg(CFG_TENSION, -32768);
    eval_query(-26000);
    write_reg(CFG_TENSION, 32767);
    eval_query(-26000);
    // count above the table acts as a full table
    write_reg(CFG_COUNT, 31);
    eval_query(5000);
    // zero-span segment
    load_point(1, -32768, 7);
    load_point(3, -40, 9);
    write_reg(CFG_COUNT, 4);
    eval_query(-32768);
    eval_query(-20000);
  endtask

  // random curves, mostly sorted, with random queries, plus some noise
  task automatic run_random_curves(input int target);
    int xs[$];
    int n;
    int q;
    while (beats_sent < target) begin
      xs = {};
      n = ($urandom_range(9) == 0) ? $urandom_range(0, 31) : $urandom_range(2, 16);
      for (int i = 0; i < MAX_POINTS; i++)
        xs.insert(xs.size(), int'($urandom_range(65535)) - 32768);
      if ($urandom_range(9) != 0) xs.sort();
      for (int i = 0; i < MAX_POINTS; i++)
        load_point(i, xs[i], int'($urandom_range(65535)) - 32768);
      case ($urandom_range(3))
        0: write_reg(CFG_TENSION, -32768);
        1: write_reg(CFG_TENSION, 32767);
        default: write_reg(CFG_TENSION, int'($urandom_range(65535)));
      endcase
      write_reg(CFG_COUNT, n);
      if (n > MAX_POINTS) n = MAX_POINTS;
      if (n < 2) n = 2;
      repeat ($urandom_range(10, 30)) begin
        case ($urandom_range(9))
          0: send_beat(1'($urandom), 4'($urandom), int'($urandom), int'($urandom),
                       int'($urandom));
          1: eval_query(xs[$urandom_range(n - 1)]);
          2: eval_query(int'($urandom));
          default: begin
            q = (xs[n-1] >= xs[0]) ? xs[0] + int'($urandom_range(xs[n-1] - xs[0]))
                                   : int'($urandom);
            eval_query(q);
          end
        endcase
      end
    end
  endtask

  // long receiver hold-off while the sender keeps offering
  task automatic test_backpressure;
    hold_off_req = 1;
    repeat (12) eval_query(int'($urandom));
    drain();
  endtask

  // stimulus
  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_TENSION;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_kind = KIND_LOAD;
    in_point_index = '0;
    in_point_in = '0;
    in_point_out = '0;
    in_query_value = '0;
    cur_tension = TENSION_RST;
    cur_count = '0;
    for (int i = 0; i < MAX_POINTS; i++) begin
      knot_x[i] = '0;
      knot_y[i] = '0;
    end
    fail_count = 0;
    beats_sent = 0;
    hold_off_req = 0;
    send_idle_pct = 29;
    recv_stall_pct = 86;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_pass_through();
    test_directed_curve();
    run_random_curves(320);
    test_backpressure();
    send_idle_pct = 86;
    recv_stall_pct = 29;
    run_random_curves(600);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    run_random_curves(830);
    drain();
    repeat (60) @(posedge clk);
    if (fail_count == 0 && curve_expect.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // receiver: random stall, or a counted hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else if (hold_off_req != 0) begin
      hold_off_req = 0;
      hold_left <= 400;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  initial out_stall = 1'b0;

  // compare each result beat with the oldest expectation
  always @(posedge clk) begin
    curve_beat_t exp_beat;
    if (rst_n && out_valid && !out_stall) begin
      if (curve_expect.size() == 0) begin
        $error("unexpected result beat: curve_value %0d", out_curve_value);
        fail_count++;
      end else begin
        exp_beat = curve_expect.pop_front();
        if (out_curve_value !== exp_beat.value) begin
          $error("curve_value: expected %0d, got %0d", exp_beat.value, out_curve_value);
          fail_count++;
        end
        if (out_saturated !== exp_beat.sat) begin
          $error("saturated: expected %0b, got %0b", exp_beat.sat, out_saturated);
          fail_count++;
        end
      end
    end
  end

  // watchdog: end the run after too long without any beat
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial quiet_cycles = 0;

endmodule

FILE: sim.f
rtl/csc_pkg.sv
rtl/csc_ram.sv
rtl/cardinal_spline_transfer_curve.sv
verif/cardinal_spline_transfer_curve_test.sv
